// ----- rtl/ihcp_pkg.sv -----
// Shared constants, types and helpers for the IP header chain parser.
// Used by ip_header_chain_parser_unit; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ihcp_pkg;

  // Capture limit: offsets at or beyond this count as no more data
  localparam int MAX_BYTES = 131072;

  // Width of the result offset ports
  localparam int FIELD_W = 18;

  // Internal offset width: holds MAX_BYTES plus one extension header overrun
  localparam int OFF_CLG = $clog2(MAX_BYTES + 2050);
  localparam int OFF_W   = (OFF_CLG > FIELD_W) ? OFF_CLG : FIELD_W;

  // Header sizes
  localparam int IPV4_MIN_HDR = 20;
  localparam int IPV6_HDR     = 40;

  // Byte positions of captured header fields
  localparam int V4_LEN_HI = 2;
  localparam int V4_LEN_LO = 3;
  localparam int V4_PROTO  = 9;
  localparam int V6_LEN_HI = 4;
  localparam int V6_LEN_LO = 5;
  localparam int V6_NEXT   = 6;

  // Version nibble that selects the IPv4 path
  localparam logic [3:0] VER_IPV4 = 4'd4;

  // IPv6 extension header next-header codes
  localparam logic [7:0] PROTO_HOPOPT   = 8'd0;
  localparam logic [7:0] PROTO_ROUTING  = 8'd43;
  localparam logic [7:0] PROTO_FRAGMENT = 8'd44;
  localparam logic [7:0] PROTO_ESP      = 8'd50;
  localparam logic [7:0] PROTO_AH       = 8'd51;
  localparam logic [7:0] PROTO_DSTOPTS  = 8'd60;
  localparam logic [7:0] PROTO_MOBILITY = 8'd135;
  localparam logic [7:0] PROTO_HIP      = 8'd139;
  localparam logic [7:0] PROTO_SHIM6    = 8'd140;

  // Snapshot of per-packet state taken on the last byte
  typedef struct packed {
    logic             v6;
    logic [3:0]       ihl;
    logic [5:0]       needed;
    logic [15:0]      declared;
    logic [7:0]       proto;
    logic [OFF_W-1:0] nes;
    logic [OFF_W-1:0] cap;
    logic [OFF_W-1:0] dec6;
  } fin_t;

  function automatic logic is_ext(input logic [7:0] p);
    logic r;
    case (p) inside
      PROTO_HOPOPT, PROTO_ROUTING, PROTO_FRAGMENT, PROTO_ESP, PROTO_AH,
      PROTO_DSTOPTS, PROTO_MOBILITY, PROTO_HIP, PROTO_SHIM6: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ip_header_chain_parser_unit.sv -----
// IP header chain parser: per-byte header tracking and end-of-packet verdict.
// Depends on ihcp_pkg for constants, the snapshot type and is_ext().
//
// Usage:
//   Input channel: one packet byte per beat (data_byte_i, last_i), starting at
//   the IP header; last_i marks the final captured byte. Beats are taken when
//   in_valid_i is high and in_stall_o is low, one per cycle sustained.
//   Output channel: one result beat per packet (status, path, upper protocol,
//   header end, packet end), taken when out_valid_o is high and out_stall_i
//   is low.
//   Path: input register, state update with snapshot stage, result register.
//   Throughput is one byte per cycle while in_stall_o is low, set by the
//   single state update stage; a packet may start in the cycle after the
//   previous last. Stall: a stalled result holds; the input register keeps
//   absorbing bytes, the snapshot stage can hold one more packet, and
//   in_stall_o rises only when a last byte cannot move into an occupied
//   snapshot stage. Config: cfg_we_i writes trust_capture_length; the user
//   must do so only while the block is idle, the block does not enforce it.
//   Reset: rst_ni clears all valids, the per-packet state and the register.
`timescale 1ns / 1ps
`default_nettype none

module ip_header_chain_parser_unit (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire                 cfg_wdata_i,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire  [7:0]          data_byte_i,
  input  wire                 last_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic                status_o,
  output logic                ipv6_path_o,
  output logic [7:0]          upper_protocol_o,
  output logic [ihcp_pkg::FIELD_W-1:0] header_end_o,
  output logic [ihcp_pkg::FIELD_W-1:0] packet_end_o
);
  import ihcp_pkg::*;

  // Configuration
  logic trust_q;

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // Per-packet state
  logic [OFF_W-1:0] off_q, off_d;
  logic             v6_q, v6_d;
  logic [3:0]       ihl_q, ihl_d;
  logic [15:0]      declared_q, declared_d;
  logic [7:0]       proto_q, proto_d;
  logic [OFF_W-1:0] nes_q, nes_d;
  logic [5:0]       needed_q, needed_d;
  logic [7:0]       ext_next_q, ext_next_d;

  // Snapshot stage and result register
  logic             fin_valid_q;
  fin_t             fin_q, fin_d;
  logic             out_valid_q;
  logic             status_q, ipv6_q;
  logic [7:0]       proto_out_q;
  logic [FIELD_W-1:0] hend_q, pend_q;

  // Handshake chain
  logic out_free, fin_free, fin_consume, s1_consume, in_accept;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign fin_consume = fin_valid_q && out_free;
  assign fin_free    = !fin_valid_q || out_free;
  assign s1_consume  = s1_valid_q && (!s1_last_q || fin_free);
  assign in_stall_o  = s1_valid_q && !s1_consume;
  assign in_accept   = in_valid_i && !in_stall_o;

  // Byte processing: update header state for the byte in the input register
  logic             live;
  logic [OFF_W-1:0] p_inc;
  logic [5:0]       ihl_x4;
  logic [11:0]      ext_len;

  always_comb begin
    live    = off_q < OFF_W'(MAX_BYTES);
    p_inc   = off_q + OFF_W'(1);
    ihl_x4  = {s1_byte_q[3:0], 2'b00};
    ext_len = {3'b000, ({1'b0, s1_byte_q} + 9'd1)} << 3;

    off_d      = off_q;
    v6_d       = v6_q;
    ihl_d      = ihl_q;
    declared_d = declared_q;
    proto_d    = proto_q;
    nes_d      = nes_q;
    needed_d   = needed_q;
    ext_next_d = ext_next_q;

    if (live) begin
      if (off_q == '0) begin
        v6_d     = s1_byte_q[7:4] != VER_IPV4;
        ihl_d    = s1_byte_q[3:0];
        needed_d = (ihl_x4 < 6'(IPV4_MIN_HDR)) ? 6'(IPV4_MIN_HDR) : ihl_x4;
      end
      if (!v6_q) begin
        if (off_q == OFF_W'(V4_LEN_HI)) declared_d = {s1_byte_q, 8'h00};
        if (off_q == OFF_W'(V4_LEN_LO)) declared_d = {declared_q[15:8],
                                                      declared_q[7:0] | s1_byte_q};
        if (off_q == OFF_W'(V4_PROTO))  proto_d = s1_byte_q;
      end else begin
        if (off_q == OFF_W'(V6_LEN_HI)) declared_d = {s1_byte_q, 8'h00};
        if (off_q == OFF_W'(V6_LEN_LO)) declared_d = {declared_q[15:8],
                                                      declared_q[7:0] | s1_byte_q};
        if (off_q == OFF_W'(V6_NEXT))   proto_d = s1_byte_q;
        // Extension chain: first byte is next header, second is length
        if (off_q >= OFF_W'(IPV6_HDR) && is_ext(proto_q)) begin
          if (off_q == nes_q) begin
            ext_next_d = s1_byte_q;
          end else if (off_q == nes_q + OFF_W'(1)) begin
            nes_d   = nes_q + OFF_W'(ext_len);
            proto_d = ext_next_q;
          end
        end
      end
      off_d = p_inc;
    end

    // Snapshot of the updated state for the verdict stage
    fin_d.v6       = v6_d;
    fin_d.ihl      = ihl_d;
    fin_d.needed   = needed_d;
    fin_d.declared = declared_d;
    fin_d.proto    = proto_d;
    fin_d.nes      = nes_d;
    fin_d.cap      = live ? p_inc : OFF_W'(MAX_BYTES);
    fin_d.dec6     = OFF_W'(IPV6_HDR) + OFF_W'(declared_d);

    // Last byte: state returns to the start-of-packet values
    if (s1_last_q) begin
      off_d      = '0;
      v6_d       = 1'b0;
      ihl_d      = '0;
      declared_d = '0;
      proto_d    = '0;
      nes_d      = OFF_W'(IPV6_HDR);
      needed_d   = '0;
      ext_next_d = '0;
    end
  end

  // Verdict from the snapshot
  logic [OFF_W-1:0] dec, pend, hend;
  logic             err;

  always_comb begin
    dec  = fin_q.v6 ? fin_q.dec6 : OFF_W'(fin_q.declared);
    pend = trust_q ? fin_q.cap : dec;
    hend = fin_q.v6 ? fin_q.nes : OFF_W'({fin_q.ihl, 2'b00});
    err  = !trust_q && (dec > fin_q.cap);
    if (fin_q.v6) begin
      if (fin_q.cap < OFF_W'(IPV6_HDR) || is_ext(fin_q.proto) || fin_q.nes > pend) begin
        err = 1'b1;
      end
    end else begin
      if (fin_q.cap < OFF_W'(fin_q.needed)) err = 1'b1;
    end
  end

  // Config register and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trust_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      off_q       <= '0;
      v6_q        <= 1'b0;
      ihl_q       <= '0;
      declared_q  <= '0;
      proto_q     <= '0;
      nes_q       <= OFF_W'(IPV6_HDR);
      needed_q    <= '0;
      ext_next_q  <= '0;
    end else begin
      if (cfg_we_i) trust_q <= cfg_wdata_i;

      if (in_accept)       s1_valid_q <= 1'b1;
      else if (s1_consume) s1_valid_q <= 1'b0;

      if (s1_consume && s1_last_q) fin_valid_q <= 1'b1;
      else if (fin_consume)        fin_valid_q <= 1'b0;

      if (fin_consume)   out_valid_q <= 1'b1;
      else if (out_free) out_valid_q <= 1'b0;

      if (s1_consume) begin
        off_q      <= off_d;
        v6_q       <= v6_d;
        ihl_q      <= ihl_d;
        declared_q <= declared_d;
        proto_q    <= proto_d;
        nes_q      <= nes_d;
        needed_q   <= needed_d;
        ext_next_q <= ext_next_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_i;
    end
    if (s1_consume && s1_last_q) fin_q <= fin_d;
    if (fin_consume) begin
      status_q    <= err;
      ipv6_q      <= err ? 1'b0 : fin_q.v6;
      proto_out_q <= err ? 8'h00 : fin_q.proto;
      hend_q      <= err ? '0 : hend[FIELD_W-1:0];
      pend_q      <= err ? '0 : pend[FIELD_W-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign ipv6_path_o      = ipv6_q;
  assign upper_protocol_o = proto_out_q;
  assign header_end_o     = hend_q;
  assign packet_end_o     = pend_q;

  // Checks
  a_off_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    off_q <= OFF_W'(MAX_BYTES))
    else $error("byte offset beyond capture limit");

  a_clear_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_consume && s1_last_q) |=> (off_q == '0 && nes_q == OFF_W'(IPV6_HDR)))
    else $error("packet state not cleared after last byte");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q) |->
      (!ipv6_q && proto_out_q == 8'h00 && hend_q == '0 && pend_q == '0))
    else $error("error result carries nonzero fields");

  a_last_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_consume && s1_last_q) |=> fin_valid_q)
    else $error("last byte lost before verdict stage");

endmodule

`default_nettype wire
